@@ rtl/bclm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bclm_pkg: shared types and constants of the bicolor LED matrix scan driver
// Matrix geometry, input mode codes and the controller-to-datapath commands.
// ----------------------------------------------------------------------------
package bclm_pkg;

    localparam int COL_CNT = 8;                 // columns (and rows) of the matrix
    localparam int COL_W   = $clog2(COL_CNT);   // bits of a column index
    localparam int ORDER_W = COL_CNT * COL_W;   // column order register width

    // Default order {3,2,1,0,4,5,6,7}, entry 0 in the low bits
    localparam logic [ORDER_W-1:0] ORDER_RESET = 24'hFAC053;

    localparam logic [COL_W-1:0] LAST_STEP = COL_W'(COL_CNT - 1);

    // Input mode codes
    localparam logic MODE_WRITE   = 1'b0;
    localparam logic MODE_REFRESH = 1'b1;

    // Controller -> datapath commands
    typedef struct packed {
        logic write;    // store the beat's column into the frame store
        logic load;     // fetch the column at the scan pointer, advance pointer
        logic shift;    // emit one shift step
        logic last;     // this shift step is the final one
    } t_cmd;

endpackage : bclm_pkg
`default_nettype wire

@@ rtl/bclm_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bclm_ctrl: scan sequencer
// Accepts beats, counts the eight shift steps of a refresh, issues commands.
// ----------------------------------------------------------------------------
module bclm_ctrl
    import bclm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_mode,
    output logic      o_busy,
    output t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_SHIFT = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_step,  n_step;
    logic               accept;
    logic               in_shift;
    logic               at_last;

    assign in_shift = (r_state == S_SHIFT);
    assign at_last  = in_shift && (r_step == LAST_STEP);
    // Busy drops on the final step so the next refresh can follow directly
    assign o_busy   = in_shift && !at_last;
    assign accept   = i_start && !o_busy;

    always_comb begin
        o_cmd.write = accept && (i_mode == MODE_WRITE);
        o_cmd.load  = accept && (i_mode == MODE_REFRESH);
        o_cmd.shift = in_shift;
        o_cmd.last  = at_last;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_SHIFT;
                    n_step  = '0;
                end
            end
            S_SHIFT: begin
                n_step = r_step + 1'b1;
                if (at_last) begin
                    n_state = o_cmd.load ? S_SHIFT : S_IDLE;
                    n_step  = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule : bclm_ctrl
`default_nettype wire

@@ rtl/bclm_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bclm_dp: frame store, scan pointer and shift-out datapath
// Holds the eight columns, serializes one column per refresh, registers outputs.
// ----------------------------------------------------------------------------
module bclm_dp
    import bclm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic [COL_W-1:0]   i_column,
    input  wire logic [COL_CNT-1:0] i_pixels,
    input  wire logic [COL_CNT-1:0] i_colors,
    input  wire logic               i_cfg_we,
    input  wire logic [ORDER_W-1:0] i_cfg_wdata,
    output logic                    o_valid,
    output logic                    o_column_select,
    output logic                    o_red_bit,
    output logic                    o_green_bit,
    output logic [COL_W-1:0]        o_scanned_column,
    output logic                    o_last_step
);

    logic [COL_CNT-1:0] r_pix_store [COL_CNT];
    logic [COL_CNT-1:0] r_clr_store [COL_CNT];
    logic [COL_W-1:0]   r_scan;
    logic [ORDER_W-1:0] r_order;

    // Working copy of the column being shifted out
    logic [COL_CNT-1:0] r_pix, r_clr;
    logic [ORDER_W-1:0] r_ord_sh;
    logic [COL_W-1:0]   r_col;

    logic               r_valid, r_sel, r_red, r_green, r_last;
    logic [COL_W-1:0]   r_out_col;

    // Control state: store, pointer, config, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < COL_CNT; i++) begin
                r_pix_store[i] <= '0;
                r_clr_store[i] <= '0;
            end
            r_scan  <= '0;
            r_order <= ORDER_RESET;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.write) begin
                r_pix_store[i_column] <= i_pixels;
                r_clr_store[i_column] <= i_colors;
            end
            if (i_cmd.load) begin
                r_scan <= r_scan + 1'b1;   // wraps modulo the column count
            end
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
            r_valid <= i_cmd.shift;
        end
    end

    // Shift registers and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix    <= r_pix_store[r_scan];
            r_clr    <= r_clr_store[r_scan];
            r_ord_sh <= r_order;
            r_col    <= r_scan;
        end else if (i_cmd.shift) begin
            r_pix    <= r_pix >> 1;
            r_clr    <= r_clr >> 1;
            r_ord_sh <= r_ord_sh >> COL_W;
        end
        if (i_cmd.shift) begin
            r_sel     <= (r_ord_sh[COL_W-1:0] == r_col);
            r_red     <= r_pix[0] & ~r_clr[0];
            r_green   <= r_pix[0] &  r_clr[0];
            r_out_col <= r_col;
            r_last    <= i_cmd.last;
        end
    end

    assign o_valid          = r_valid;
    assign o_column_select  = r_sel;
    assign o_red_bit        = r_red;
    assign o_green_bit      = r_green;
    assign o_scanned_column = r_out_col;
    assign o_last_step      = r_last;

endmodule : bclm_dp
`default_nettype wire

@@ rtl/bicolor_led_matrix_scan_driver.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bicolor_led_matrix_scan_driver: 8x8 red/green LED matrix column-scan driver
// Keeps a frame store of eight columns and serializes one column per refresh
// into column-select, red and green shift-register data bits.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------
//  command   | i_start, o_busy           | i_mode, i_column, i_pixels, i_colors
//  result    | o_valid (strobe)          | o_column_select, o_red_bit,
//            |                           | o_green_bit, o_scanned_column,
//            |                           | o_last_step
//  config    | i_cfg_we                  | i_cfg_wdata (column order)
//
//  A beat is taken on a rising edge with i_start high and o_busy low.
//  Write beats give no result; o_busy stays low.
//  A refresh beat gives eight result strobes on consecutive cycles, the first
//  registered by the output stage after the sequencer enters its shift state;
//  the step counter in the sequencer paces the shift steps, and o_busy falls
//  during the last step so another refresh beat is taken then, back to back.
//  Results cannot be stalled: each is on the ports for exactly one cycle.
//  Synchronous active-low reset clears the frame store, the scan pointer and
//  reloads the default column order {3,2,1,0,4,5,6,7}.
// ----------------------------------------------------------------------------
module bicolor_led_matrix_scan_driver
    import bclm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // command channel
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic               i_mode,
    input  wire logic [COL_W-1:0]   i_column,
    input  wire logic [COL_CNT-1:0] i_pixels,
    input  wire logic [COL_CNT-1:0] i_colors,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [ORDER_W-1:0] i_cfg_wdata,
    // result channel
    output logic                    o_valid,
    output logic                    o_column_select,
    output logic                    o_red_bit,
    output logic                    o_green_bit,
    output logic [COL_W-1:0]        o_scanned_column,
    output logic                    o_last_step
);

    t_cmd cmd;

    // Sequencer: accepts beats and paces the eight shift steps
    bclm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_mode  (i_mode),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    // Frame store, scan pointer, column order and output registers
    bclm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_column         (i_column),
        .i_pixels         (i_pixels),
        .i_colors         (i_colors),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_column_select  (o_column_select),
        .o_red_bit        (o_red_bit),
        .o_green_bit      (o_green_bit),
        .o_scanned_column (o_scanned_column),
        .o_last_step      (o_last_step)
    );

endmodule : bicolor_led_matrix_scan_driver
`default_nettype wire

@@ rtl/bclm_chk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bclm_chk: port-level checker for the scan driver
// Watches strobe bursts and refresh timing; bound to the top level.
// ----------------------------------------------------------------------------
module bclm_chk
    import bclm_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_start,
    input wire logic             i_mode,
    input wire logic             o_busy,
    input wire logic             o_valid,
    input wire logic             o_last_step,
    input wire logic [COL_W-1:0] o_scanned_column
);

    // Refresh accepted -> first strobe after the load and output registers
    a_refresh_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_mode == MODE_REFRESH) |=> ##1 o_valid)
        else $error("refresh beat did not produce a strobe");

    // A burst runs without gaps until its last step
    a_burst_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_step) |=> o_valid)
        else $error("gap inside a shift burst");

    // Column stays fixed across one burst
    a_burst_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_step) |=> $stable(o_scanned_column))
        else $error("scanned column changed within a burst");

    // Write beats accepted while no strobe is out do not make the block busy
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_mode == MODE_WRITE && !o_valid) |=> !o_busy)
        else $error("write beat raised busy");

endmodule : bclm_chk

bind bicolor_led_matrix_scan_driver bclm_chk u_bclm_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_start          (i_start),
    .i_mode           (i_mode),
    .o_busy           (o_busy),
    .o_valid          (o_valid),
    .o_last_step      (o_last_step),
    .o_scanned_column (o_scanned_column)
);
`default_nettype wire
